@@ rtl/bis_pkg.sv @@
// bis_pkg: operation codes and sequencer state type for the bitmap integer set
`timescale 1ns / 1ps
`default_nettype none

package bis_pkg;

  localparam logic [2:0] OP_ADD     = 3'd0;
  localparam logic [2:0] OP_REMOVE  = 3'd1;
  localparam logic [2:0] OP_TEST    = 3'd2;
  localparam logic [2:0] OP_RESTART = 3'd3;
  localparam logic [2:0] OP_NEXT    = 3'd4;
  localparam logic [2:0] OP_CLEAR   = 3'd5;

  localparam logic [7:0] CAPACITY_RESET = 8'd128;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_TEST,
    ST_SCAN,
    ST_HOLD
  } state_t;

endpackage

`default_nettype wire

@@ rtl/bitmap_integer_set.sv @@
// bitmap_integer_set: membership bitmap in a byte-wide memory with find-next-member scan
// add and remove read the item's bitmap byte and write it back in ST_UPDATE; test takes
// its bit in ST_TEST; restart, clear, unused codes and out-of-range items go straight to
// ST_HOLD; next walks bitmap bytes in ST_SCAN up to bound = min(capacity, SET_SIZE)
// one operation at a time, taken only in ST_IDLE; a stalled result holds the block
// reset: synchronous, clears per-byte valid bits, high-water mark and cursor; capacity 128
`timescale 1ns / 1ps
`default_nettype none

module bitmap_integer_set
  import bis_pkg::*;
#(
  parameter int SET_SIZE = 128
) (
  input  wire logic       clk,
  input  wire logic       rst,
  // configuration
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data,
  // operations
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] op,
  input  wire logic [6:0] item,
  // results
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            member,
  output logic [6:0]      next_item,
  output logic            at_end,
  output logic            is_empty,
  output logic [7:0]      high_water
);

  localparam int NROWS    = (SET_SIZE + 7) / 8;
  localparam int RW       = (NROWS > 1) ? $clog2(NROWS) : 1;
  localparam int BOUND_HI = (SET_SIZE < 255) ? SET_SIZE : 255;

  state_t state, state_next;

  logic [7:0] capacity;
  logic [7:0] high_mark, high_mark_next;
  logic [7:0] cursor, cursor_next;
  logic [2:0] op_r;
  logic [6:0] item_r;

  logic       res_member, res_member_next;
  logic [6:0] res_next, res_next_next;
  logic       res_at_end, res_at_end_next;

  // byte memory with a valid bit per row
  logic [7:0]       mem [NROWS];
  logic [NROWS-1:0] row_valid;
  logic [7:0]       rd_data;
  logic             rd_valid;
  logic [RW-1:0]    rd_addr;
  logic             wr_en;
  logic [RW-1:0]    wr_addr;
  logic [7:0]       wr_data;
  logic             clear_all;

  logic [RW-1:0] cur_row;
  logic [RW-1:0] in_row;
  logic [RW-1:0] item_row;
  logic [7:0]    bound;
  logic [7:0]    row_byte;
  logic [7:0]    bit_mask;
  logic          in_range;
  logic [7:0]    cand;
  logic          found;
  logic [2:0]    found_idx;
  logic [7:0]    found_pos;
  logic [8:0]    next_row_base;
  logic          out_load;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign out_load  = (state == ST_HOLD) && (!out_valid || out_ready);

  assign cur_row  = RW'(cursor >> 3);
  assign in_row   = RW'(item >> 3);
  assign item_row = RW'(item_r >> 3);
  assign in_range = (32'(item) < SET_SIZE);
  assign bound    = (32'(capacity) < SET_SIZE) ? capacity : 8'(BOUND_HI);
  assign row_byte = rd_valid ? rd_data : 8'd0;
  assign bit_mask = 8'd1 << item_r[2:0];

  // candidate bits at or after the cursor and below the bound
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      cand[b] = row_byte[b] && (3'(b) >= cursor[2:0]) && ({cursor[7:3], 3'(b)} < bound);
    end
    found     = 1'b0;
    found_idx = 3'd0;
    for (int b = 7; b >= 0; b--) begin
      if (cand[b]) begin
        found     = 1'b1;
        found_idx = 3'(b);
      end
    end
  end

  assign found_pos     = {cursor[7:3], found_idx};
  assign next_row_base = {1'b0, cursor[7:3], 3'b000} + 9'd8;

  always_comb begin
    state_next      = state;
    high_mark_next  = high_mark;
    cursor_next     = cursor;
    res_member_next = res_member;
    res_next_next   = res_next;
    res_at_end_next = res_at_end;
    rd_addr         = cur_row;
    wr_en           = 1'b0;
    wr_addr         = item_row;
    wr_data         = row_byte;
    clear_all       = 1'b0;
    case (state)
      ST_IDLE: begin
        rd_addr = (op == OP_NEXT) ? cur_row : in_row;
        if (in_valid) begin
          res_member_next = 1'b0;
          res_next_next   = 7'd0;
          res_at_end_next = 1'b0;
          state_next      = ST_HOLD;
          case (op)
            OP_ADD, OP_REMOVE: begin
              if (in_range) begin
                state_next = ST_UPDATE;
              end
            end
            OP_TEST: begin
              if (in_range) begin
                state_next = ST_TEST;
              end
            end
            OP_RESTART: begin
              cursor_next = 8'd0;
            end
            OP_NEXT: begin
              if (cursor >= bound) begin
                res_at_end_next = 1'b1;
              end else begin
                state_next = ST_SCAN;
              end
            end
            OP_CLEAR: begin
              clear_all      = 1'b1;
              high_mark_next = 8'd0;
              cursor_next    = 8'd0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_UPDATE: begin
        wr_en = 1'b1;
        if (op_r == OP_ADD) begin
          wr_data = row_byte | bit_mask;
          if (high_mark < ({1'b0, item_r} + 8'd1)) begin
            high_mark_next = {1'b0, item_r} + 8'd1;
          end
        end else begin
          wr_data = row_byte & ~bit_mask;
        end
        state_next = ST_HOLD;
      end
      ST_TEST: begin
        res_member_next = row_byte[item_r[2:0]];
        state_next      = ST_HOLD;
      end
      ST_SCAN: begin
        // fetch the following row while this one is examined
        rd_addr = cur_row + RW'(1);
        if (found) begin
          res_next_next = found_pos[6:0];
          cursor_next   = found_pos + 8'd1;
          state_next    = ST_HOLD;
        end else if (next_row_base >= {1'b0, bound}) begin
          cursor_next     = bound;
          res_at_end_next = 1'b1;
          state_next      = ST_HOLD;
        end else begin
          cursor_next = next_row_base[7:0];
        end
      end
      ST_HOLD: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      rd_valid <= row_valid[rd_addr] && !(wr_en && (wr_addr == rd_addr));
      if (clear_all) begin
        row_valid <= '0;
      end else if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      capacity   <= CAPACITY_RESET;
      high_mark  <= 8'd0;
      cursor     <= 8'd0;
      out_valid  <= 1'b0;
    end else begin
      state     <= state_next;
      high_mark <= high_mark_next;
      cursor    <= cursor_next;
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_member <= res_member_next;
    res_next   <= res_next_next;
    res_at_end <= res_at_end_next;
    if (state == ST_IDLE && in_valid) begin
      op_r   <= op;
      item_r <= item;
    end
    if (out_load) begin
      member     <= res_member;
      next_item  <= res_next;
      at_end     <= res_at_end;
      is_empty   <= (high_mark == 8'd0);
      high_water <= high_mark;
    end
  end

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// testbench for bitmap_integer_set: directed and random set operations checked against a predictor
`timescale 1ns / 1ps

module testbench;
  import bis_pkg::*;

  localparam int SET_SIZE = 128;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_OPS = 450;
  // codes that the block must treat as no-ops
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  typedef struct packed {
    logic       member;
    logic [6:0] next_item;
    logic       at_end;
    logic       is_empty;
    logic [7:0] high_water;
  } set_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = 8'd0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] op = OP_ADD;
  logic [6:0] item = 7'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       member;
  logic [6:0] next_item;
  logic       at_end;
  logic       is_empty;
  logic [7:0] high_water;

  // predicted state of the set
  logic [SET_SIZE-1:0] members_now;
  logic [7:0]          mark_now;
  logic [7:0]          cursor_now;
  logic [7:0]          capacity_now;

  set_result_t expected_results[$];
  int          error_count = 0;
  int          ops_sent = 0;
  int          burst_left = 0;
  int          idle_cycles = 0;
  logic [7:0]  stall_phase = 8'd0;

  bitmap_integer_set #(.SET_SIZE(SET_SIZE)) DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .item       (item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .member     (member),
    .next_item  (next_item),
    .at_end     (at_end),
    .is_empty   (is_empty),
    .high_water (high_water)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [7:0] scan_limit();
    return (capacity_now < SET_SIZE) ? capacity_now : 8'(SET_SIZE);
  endfunction

  function automatic set_result_t apply_set_op(input logic [2:0] code, input logic [6:0] value);
    set_result_t r;
    logic [7:0]  bound;
    r = '0;
    bound = scan_limit();
    case (code)
      OP_ADD: begin
        members_now[value] = 1'b1;
        if (mark_now < {1'b0, value} + 8'd1) mark_now = {1'b0, value} + 8'd1;
      end
      OP_REMOVE: members_now[value] = 1'b0;
      OP_TEST: r.member = members_now[value];
      OP_RESTART: cursor_now = 8'd0;
      OP_NEXT: begin
        // bound is tested before the bitmap is looked at
        if (cursor_now >= bound) begin
          r.at_end = 1'b1;
        end else begin
          while (cursor_now < bound && !members_now[cursor_now[6:0]]) cursor_now++;
          if (cursor_now >= bound) begin
            cursor_now = bound;
            r.at_end = 1'b1;
          end else begin
            r.next_item = cursor_now[6:0];
            cursor_now++;
          end
        end
      end
      OP_CLEAR: begin
        members_now = '0;
        mark_now = 8'd0;
        cursor_now = 8'd0;
      end
      default: ;
    endcase
    r.is_empty = (mark_now == 8'd0);
    r.high_water = mark_now;
    return r;
  endfunction

  // called at a falling edge; returns at a falling edge with in_valid still high mid-burst
  task automatic send_op(input logic [2:0] code, input logic [6:0] value);
    int gap;
    in_valid = 1'b1;
    op = code;
    item = value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_results.push_back(apply_set_op(code, value));
    ops_sent++;
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 10);
    end
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [7:0] value);
    drain_results();
    cfg_valid = 1'b1;
    cfg_data = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    capacity_now = value;
    @(negedge clk);
    cfg_valid = 1'b0;
    cfg_data = 8'($urandom);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    set_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result transaction with nothing outstanding");
        error_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("member", int'(want.member), int'(member));
        check_field("next_item", int'(want.next_item), int'(next_item));
        check_field("at_end", int'(want.at_end), int'(at_end));
        check_field("is_empty", int'(want.is_empty), int'(is_empty));
        check_field("high_water", int'(want.high_water), int'(high_water));
      end
    end
  end

  // receiver: ready throughout, periodic single stalls, random, then long stalls
  always @(negedge clk) begin
    stall_phase <= stall_phase + 8'd1;
    case (stall_phase[7:6])
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= (stall_phase[2:0] != 3'd0);
      2'd2: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= (stall_phase[4:0] < 5'd20);
    endcase
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic test_after_reset();
    send_op(OP_TEST, 7'd0);
    send_op(OP_NEXT, 7'd127);
    send_op(OP_SPARE_6, 7'd127);
    send_op(OP_SPARE_7, 7'd0);
  endtask

  task automatic test_item_extremes();
    send_op(OP_ADD, 7'd0);
    send_op(OP_ADD, 7'd127);
    send_op(OP_TEST, 7'd0);
    send_op(OP_TEST, 7'd127);
    send_op(OP_RESTART, 7'd85);
    send_op(OP_NEXT, 7'd0);
    send_op(OP_NEXT, 7'd42);
    send_op(OP_NEXT, 7'd0);
    // mark stays up after removal, so the set reads non-empty with no members
    send_op(OP_REMOVE, 7'd127);
    send_op(OP_TEST, 7'd127);
    send_op(OP_REMOVE, 7'd0);
    send_op(OP_CLEAR, 7'd127);
  endtask

  task automatic test_capacity_bound();
    write_capacity(8'd1);
    send_op(OP_ADD, 7'd0);
    send_op(OP_ADD, 7'd5);
    send_op(OP_RESTART, 7'd0);
    send_op(OP_NEXT, 7'd0);
    send_op(OP_NEXT, 7'd0);
    write_capacity(8'd0);
    send_op(OP_NEXT, 7'd0);
    // above the set size the scan is bounded by the set size
    write_capacity(8'd255);
    send_op(OP_NEXT, 7'd0);
    // cursor left beyond a lowered bound: end at once, cursor kept
    write_capacity(8'd3);
    send_op(OP_NEXT, 7'd0);
    write_capacity(8'd128);
    send_op(OP_NEXT, 7'd0);
  endtask

  task automatic test_random_sets();
    logic [7:0] phase_caps[8];
    logic [7:0] bound;
    int         target;
    int         pick;
    int         steps;
    phase_caps = '{8'd128, 8'd1, 8'd64, 8'd200, 8'd8, 8'd127, 8'd0, 8'd128};
    phase_caps[7] = 8'($urandom_range(1, 128));
    for (int p = 0; p < 8; p++) begin
      write_capacity(phase_caps[p]);
      bound = scan_limit();
      target = ops_sent + RANDOM_OPS / 8;
      while (ops_sent < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
          // mostly inside the scan bound so that iteration finds members
          if (bound > 0 && $urandom_range(0, 3) != 0)
            send_op(OP_ADD, 7'($urandom_range(0, bound - 1)));
          else
            send_op(OP_ADD, 7'($urandom));
        end else if (pick < 45) begin
          send_op(OP_REMOVE, 7'($urandom));
        end else if (pick < 57) begin
          send_op(OP_TEST, 7'($urandom));
        end else if (pick < 80) begin
          send_op(OP_RESTART, 7'($urandom));
          steps = 0;
          while (cursor_now < bound && steps < 20) begin
            send_op(OP_NEXT, 7'($urandom));
            steps++;
          end
          send_op(OP_NEXT, 7'($urandom));
        end else if (pick < 88) begin
          send_op(OP_NEXT, 7'($urandom));
        end else if (pick < 91) begin
          send_op(OP_RESTART, 7'($urandom));
        end else if (pick < 94) begin
          send_op(OP_CLEAR, 7'($urandom));
        end else if (pick < 98) begin
          send_op($urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7, 7'($urandom));
        end else begin
          drain_results();
        end
      end
    end
  endtask

  initial begin
    members_now = '0;
    mark_now = 8'd0;
    cursor_now = 8'd0;
    capacity_now = CAPACITY_RESET;
    repeat (4) @(negedge clk);
    rst = 1'b0;
    test_after_reset();
    test_item_extremes();
    test_capacity_bound();
    test_random_sets();
    drain_results();
    repeat (20) @(negedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
